// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion helpers included by stereo_biquad_eq_cascade
// all properties sample on clk and are disabled while rst is high
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- design/sbeq_pkg.sv -----
// ----------------------------------------------------------------------------
// sbeq_pkg
// fixed field widths and codes of the stereo biquad equalizer cascade
// ----------------------------------------------------------------------------
`default_nettype none

package sbeq_pkg;

  localparam int COEF_W      = 32;
  localparam int STATE_W     = 40;
  localparam int STAGE_SEL_W = 4;
  localparam int COEF_SEL_W  = 3;
  localparam int CFG_INDEX_W = 3;
  localparam int NUM_COEFS   = 5;

  // request kinds
  localparam logic OP_FILTER     = 1'b0;
  localparam logic OP_COEF_WRITE = 1'b1;

  // coefficient slots within one stage
  localparam logic [COEF_SEL_W-1:0] COEF_B0 = 3'd0;
  localparam logic [COEF_SEL_W-1:0] COEF_B1 = 3'd1;
  localparam logic [COEF_SEL_W-1:0] COEF_B2 = 3'd2;
  localparam logic [COEF_SEL_W-1:0] COEF_A1 = 3'd3;
  localparam logic [COEF_SEL_W-1:0] COEF_A2 = 3'd4;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_STEREO_MODE     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_EQ_ENABLE       = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_EQ_BANDS_ACTIVE = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_BASS_ACTIVE     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_TREBLE_ACTIVE   = 3'd4;

  // state word slots within one stage
  localparam logic W_SLOT_1 = 1'b0;
  localparam logic W_SLOT_2 = 1'b1;

endpackage

`default_nettype wire

// ----- design/sbeq_ram.sv -----
// ----------------------------------------------------------------------------
// sbeq_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module sbeq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- design/stereo_biquad_eq_cascade.sv -----
// ----------------------------------------------------------------------------
// stereo_biquad_eq_cascade
// twelve-stage transposed direct form ii biquad cascade on one shared
// multiplier, per-channel state, coefficients written in band
// ----------------------------------------------------------------------------
//   channel  signals                               direction  carries
//   cfg      cfg_valid/ready, cfg_index, cfg_data  in         mode and enable bits
//   s        s_tvalid/tready, s_tdata, s_tuser     in         sample or coef write
//   m        m_tvalid/tready, m_tdata, m_tuser     out        filtered sample
//
// a filter request runs from accept through a prime state, the five products
// of each active stage in turn on the one 32 x SAMPLE_BITS multiplier, a
// flush state and the output state that loads the output register; with every
// stage bypassed it goes from prime straight to the output state. input reopens
// once the output register is loaded. a coefficient write gives no result.
// input is closed while a sample is in work; the output register holds a
// finished sample while the next request is accepted, and the next finished
// sample waits in the output state until that register is taken.
// rst is synchronous; coefficients read as identity and state as zero until
// written, through per-entry valid flops cleared by rst.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_biquad_eq_cascade #(
  parameter int PEAK_BANDS     = 10,
  parameter int CHANNELS       = 2,
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_FRAC_BITS = 28
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [sbeq_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic                                   cfg_data,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // sample_in, stage_sel, coef_sel, coef_value, zero pad
  input  logic [((SAMPLE_BITS+39+7)/8)*8-1:0]    s_tdata,
  // opcode, channel_in
  input  logic [1:0]                             s_tuser,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // sample_out, zero pad
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]       m_tdata,
  // channel_out
  output logic                                   m_tuser
);

  import sbeq_pkg::*;

  localparam int NUM_STAGES = PEAK_BANDS + 2;
  localparam int STAGE_W    = $clog2(NUM_STAGES);
  localparam int OUT_W      = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int PW         = COEF_W + SAMPLE_BITS;
  localparam int ACC_W      = PW + 2;
  localparam int CDEPTH     = NUM_STAGES << COEF_SEL_W;
  localparam int CADDR_W    = STAGE_W + COEF_SEL_W;
  localparam int SDEPTH     = CHANNELS << (STAGE_W + 1);
  localparam int SADDR_W    = $clog2(SDEPTH);
  localparam int OFS_STAGE  = SAMPLE_BITS;
  localparam int OFS_CSEL   = OFS_STAGE + STAGE_SEL_W;
  localparam int OFS_CVAL   = OFS_CSEL + COEF_SEL_W;

  localparam logic [STAGE_W-1:0] STG_LAST_BAND = STAGE_W'(PEAK_BANDS - 1);
  localparam logic [STAGE_W-1:0] STG_BASS      = STAGE_W'(PEAK_BANDS);
  localparam logic [STAGE_W-1:0] STG_TREBLE    = STAGE_W'(PEAK_BANDS + 1);
  localparam logic [STAGE_W-1:0] STG_FIRST     = '0;
  localparam logic [STAGE_SEL_W:0] STAGE_LIMIT = (STAGE_SEL_W + 1)'(NUM_STAGES);

  localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(64'd1 << COEF_FRAC_BITS);
  localparam logic signed [PW:0]       HALF     = (PW + 1)'(64'd1 << (COEF_FRAC_BITS - 1));
  localparam logic signed [ACC_W-1:0]  SMAX =
    {{(ACC_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0]  SMIN = ~SMAX;
  localparam logic signed [ACC_W-1:0]  WMAX =
    {{(ACC_W - STATE_W + 1){1'b0}}, {(STATE_W - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0]  WMIN = ~WMAX;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRIME,
    ST_MUL_B0,
    ST_MUL_B1,
    ST_MUL_A1,
    ST_MUL_B2,
    ST_MUL_A2,
    ST_FLUSH,
    ST_OUT
  } state_t;

  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
    input logic signed [ACC_W-1:0] v
  );
    logic signed [ACC_W-1:0] c;
    begin
      c = (v > SMAX) ? SMAX : ((v < SMIN) ? SMIN : v);
      return c[SAMPLE_BITS-1:0];
    end
  endfunction

  function automatic logic signed [STATE_W-1:0] sat_state(
    input logic signed [ACC_W-1:0] v
  );
    logic signed [ACC_W-1:0] c;
    begin
      c = (v > WMAX) ? WMAX : ((v < WMIN) ? WMIN : v);
      return c[STATE_W-1:0];
    end
  endfunction

  // request fields
  logic                          in_opcode;
  logic                          in_chan;
  logic signed [SAMPLE_BITS-1:0] in_sample;
  logic [STAGE_SEL_W-1:0]        in_stage;
  logic [COEF_SEL_W-1:0]         in_csel;
  logic [COEF_W-1:0]             in_cval;

  // control
  state_t                 state;
  logic [STAGE_W-1:0]     stage;
  logic [STAGE_W-1:0]     prev_stage;
  logic                   pend;
  logic                   ch;
  logic                   chan_keep;
  logic                   nxt_ok;
  logic [STAGE_W-1:0]     nxt_stage;
  logic                   stereo_mode;
  logic                   eq_enable;
  logic                   eq_bands_active;
  logic                   bass_active;
  logic                   treble_active;
  logic                   bands_on;
  logic                   accept;

  // datapath
  logic signed [SAMPLE_BITS-1:0] x_reg;
  logic signed [SAMPLE_BITS-1:0] y_reg;
  logic signed [SAMPLE_BITS-1:0] mul_b;
  logic signed [PW-1:0]          prod;
  logic signed [PW:0]            rnd_full;
  logic signed [ACC_W-1:0]       rnd;
  logic signed [ACC_W-1:0]       acc;
  logic signed [STATE_W-1:0]     w_hold;
  logic signed [ACC_W-1:0]       w_ext;
  logic [SAMPLE_BITS-1:0]        out_sample;

  // coefficient store
  logic                   coef_we;
  logic [CADDR_W-1:0]     coef_waddr;
  logic [CADDR_W-1:0]     coef_raddr;
  logic [COEF_W-1:0]      coef_rdata;
  logic [CDEPTH-1:0]      coef_vld;
  logic                   coef_rvld;
  logic                   coef_rb0;
  logic signed [COEF_W-1:0] coef_q;

  // filter state store
  logic                   st_we;
  logic [SADDR_W-1:0]     st_waddr;
  logic [SADDR_W-1:0]     st_raddr;
  logic [STATE_W-1:0]     st_wdata;
  logic [STATE_W-1:0]     st_rdata;
  logic [SDEPTH-1:0]      st_vld;
  logic                   st_rvld;
  logic signed [STATE_W-1:0] st_q;

  assign in_opcode = s_tuser[0];
  assign in_chan   = s_tuser[1];
  assign in_sample = s_tdata[SAMPLE_BITS-1:0];
  assign in_stage  = s_tdata[OFS_STAGE +: STAGE_SEL_W];
  assign in_csel   = s_tdata[OFS_CSEL +: COEF_SEL_W];
  assign in_cval   = s_tdata[OFS_CVAL +: COEF_W];

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign bands_on  = eq_enable && eq_bands_active;
  assign m_tdata   = OUT_W'(out_sample);

  // next active stage in the cascade
  always_comb begin
    nxt_ok    = 1'b1;
    nxt_stage = STG_FIRST;
    if (state == ST_PRIME) begin
      if (bands_on) begin
        nxt_stage = STG_FIRST;
      end else if (bass_active) begin
        nxt_stage = STG_BASS;
      end else if (treble_active) begin
        nxt_stage = STG_TREBLE;
      end else begin
        nxt_ok = 1'b0;
      end
    end else begin
      if (stage < STG_LAST_BAND) begin
        nxt_stage = stage + STAGE_W'(1);
      end else if (stage < STG_BASS && bass_active) begin
        nxt_stage = STG_BASS;
      end else if (stage < STG_TREBLE && treble_active) begin
        nxt_stage = STG_TREBLE;
      end else begin
        nxt_ok = 1'b0;
      end
    end
  end

  // coefficient port
  assign coef_we = accept && (in_opcode == OP_COEF_WRITE) &&
                   ({1'b0, in_stage} < STAGE_LIMIT) &&
                   (in_csel < COEF_SEL_W'(NUM_COEFS));
  assign coef_waddr = {STAGE_W'(in_stage), in_csel};

  always_comb begin
    case (state)
      ST_MUL_B0: coef_raddr = {stage, COEF_B1};
      ST_MUL_B1: coef_raddr = {stage, COEF_A1};
      ST_MUL_A1: coef_raddr = {stage, COEF_B2};
      ST_MUL_B2: coef_raddr = {stage, COEF_A2};
      default:   coef_raddr = {nxt_stage, COEF_B0};
    endcase
  end

  assign coef_q = coef_rvld ? $signed(coef_rdata) : (coef_rb0 ? COEF_ONE : '0);

  sbeq_ram #(
    .WIDTH (COEF_W),
    .DEPTH (CDEPTH)
  ) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (in_cval),
    .raddr (coef_raddr),
    .rdata (coef_rdata)
  );

  // state port: w1 of a stage is written after its a1 product, w2 after a2
  always_comb begin
    case (state)
      ST_MUL_B0: st_raddr = SADDR_W'({ch, stage, W_SLOT_2});
      default:   st_raddr = SADDR_W'({ch, nxt_stage, W_SLOT_1});
    endcase
    case (state)
      ST_MUL_B0: st_waddr = SADDR_W'({ch, prev_stage, W_SLOT_2});
      ST_MUL_B2: st_waddr = SADDR_W'({ch, stage, W_SLOT_1});
      default:   st_waddr = SADDR_W'({ch, stage, W_SLOT_2});
    endcase
  end

  assign st_we    = (state == ST_MUL_B0 && pend) || (state == ST_MUL_B2) ||
                    (state == ST_FLUSH);
  assign st_wdata = sat_state(acc - rnd);
  assign st_q     = st_rvld ? $signed(st_rdata) : '0;

  sbeq_ram #(
    .WIDTH (STATE_W),
    .DEPTH (SDEPTH)
  ) u_state_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // shared product path
  assign mul_b    = (state == ST_MUL_A1 || state == ST_MUL_A2) ? y_reg : x_reg;
  assign rnd_full = ($signed({prod[PW-1], prod}) + HALF) >>> COEF_FRAC_BITS;
  assign rnd      = {{(ACC_W - PW - 1){rnd_full[PW]}}, rnd_full};
  assign w_ext    = {{(ACC_W - STATE_W){w_hold[STATE_W-1]}}, w_hold};

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      pend            <= 1'b0;
      m_tvalid        <= 1'b0;
      stereo_mode     <= 1'b1;
      eq_enable       <= 1'b1;
      eq_bands_active <= 1'b0;
      bass_active     <= 1'b0;
      treble_active   <= 1'b0;
      coef_vld        <= '0;
      st_vld          <= '0;
      coef_rvld       <= 1'b0;
      st_rvld         <= 1'b0;
    end else begin
      coef_rvld <= coef_vld[coef_raddr];
      coef_rb0  <= (coef_raddr[COEF_SEL_W-1:0] == COEF_B0);
      st_rvld   <= st_vld[st_raddr];
      if (coef_we) begin
        coef_vld[coef_waddr] <= 1'b1;
      end
      if (st_we) begin
        st_vld[st_waddr] <= 1'b1;
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_STEREO_MODE:     stereo_mode     <= cfg_data;
          REG_EQ_ENABLE:       eq_enable       <= cfg_data;
          REG_EQ_BANDS_ACTIVE: eq_bands_active <= cfg_data;
          REG_BASS_ACTIVE:     bass_active     <= cfg_data;
          REG_TREBLE_ACTIVE:   treble_active   <= cfg_data;
          default: ;
        endcase
      end

      // the output state reloads the register itself
      if (m_tvalid && m_tready && state != ST_OUT) begin
        m_tvalid <= 1'b0;
      end

      if (state == ST_MUL_B0 || state == ST_MUL_B1 || state == ST_MUL_A1 ||
          state == ST_MUL_B2 || state == ST_MUL_A2) begin
        prod <= coef_q * mul_b;
      end

      case (state)
        ST_IDLE: begin
          if (accept && in_opcode == OP_FILTER) begin
            x_reg     <= in_sample;
            chan_keep <= in_chan;
            ch        <= (stereo_mode && CHANNELS > 1) ? in_chan : 1'b0;
            state     <= ST_PRIME;
          end
        end
        ST_PRIME: begin
          pend <= 1'b0;
          if (nxt_ok) begin
            stage <= nxt_stage;
            state <= ST_MUL_B0;
          end else begin
            state <= ST_OUT;
          end
        end
        ST_MUL_B0: begin
          w_hold <= st_q;
          pend   <= 1'b0;
          state  <= ST_MUL_B1;
        end
        ST_MUL_B1: begin
          y_reg  <= sat_sample(rnd + w_ext);
          w_hold <= st_q;
          state  <= ST_MUL_A1;
        end
        ST_MUL_A1: begin
          acc   <= rnd + w_ext;
          state <= ST_MUL_B2;
        end
        ST_MUL_B2: begin
          state <= ST_MUL_A2;
        end
        ST_MUL_A2: begin
          acc   <= rnd;
          x_reg <= y_reg;
          if (nxt_ok) begin
            // w2 of this stage is stored during the next stage's first product
            prev_stage <= stage;
            stage      <= nxt_stage;
            pend       <= 1'b1;
            state      <= ST_MUL_B0;
          end else begin
            state <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid   <= 1'b1;
            out_sample <= x_reg;
            m_tuser    <= chan_keep;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`include "assert_macros.svh"

  `ASSERT_NEXT(a_filter_closes_input, accept && (in_opcode == OP_FILTER), !s_tready, "filter request left input open")
  `ASSERT_IMPLY(a_result_from_out_state, $rose(m_tvalid), $past(state) == ST_OUT, "result loaded outside output state")
  `ASSERT_IMPLY(a_pending_w2_in_first_mul, pend, state == ST_MUL_B0, "pending state write outside first product")

endmodule

`default_nettype wire
